>>> src/joint_setpoint_smoother_core_macros.svh
// ----------------------------------------------------------------------------
// Joint setpoint smoother assertion macros
// Short forms for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef JOINT_SETPOINT_SMOOTHER_CORE_MACROS_SVH
`define JOINT_SETPOINT_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication
`define JSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/jss_pkg.sv
// ----------------------------------------------------------------------------
// Joint setpoint smoother package
// Widths, fixed-point constants, command codes, sequencer states and the
// saturation helper shared by the smoother modules.
// ----------------------------------------------------------------------------
package jss_pkg;

   // Data format
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_W     = DATA_WIDTH + 1;

   // Shared multiplier: wide enough for Q.32 weights and the scale span
   localparam int MUL_W  = (DATA_WIDTH + 1 > 33) ? DATA_WIDTH + 1 : 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + 2;

   // Weights and degree factor are Q.32 fractions
   localparam int WSHIFT = 32;
   localparam logic signed [MUL_W-1:0] W_NEW   = MUL_W'(64'sd3006477107);
   localparam logic signed [MUL_W-1:0] W_MID   = MUL_W'(64'sd858993459);
   localparam logic signed [MUL_W-1:0] W_OLD   = MUL_W'(64'sd429496730);
   localparam logic signed [MUL_W-1:0] DEG2RAD = MUL_W'(64'sd74961321);

   // One in fixed point, and the 0.001 rad dead band
   localparam logic signed [DIFF_W-1:0] ONE_FX = DIFF_W'(1) << FRAC_BITS;
   localparam int DEADBAND = (1 << FRAC_BITS) / 1000;
   localparam logic signed [DIFF_W-1:0] DB_HI = DIFF_W'(DEADBAND);
   localparam logic signed [DIFF_W-1:0] DB_LO = DIFF_W'(-DEADBAND);

   // Register reset values
   localparam logic signed [DATA_WIDTH-1:0] MAX_ANGLE_RST = DATA_WIDTH'(205887);
   localparam logic signed [DATA_WIDTH-1:0] MIN_ANGLE_RST = DATA_WIDTH'(-205887);

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ANGLE = 1'b1;

   // Commands and units
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_INIT = 1'b1;
   localparam logic [1:0] UNIT_RAD   = 2'd0;
   localparam logic [1:0] UNIT_DEG   = 2'd1;
   localparam logic [1:0] UNIT_SCALE = 2'd2;

   // Saturation bounds at accumulator width
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_UNIT,
      ST_MUL_NEW,
      ST_MUL_MID,
      ST_MUL_OLD,
      ST_SUM,
      ST_SLOPE,
      ST_OUT
   } state_type;

   // Clamp a wide signed value to the data width
   function automatic logic signed [DATA_WIDTH-1:0] sat_acc(
      input logic signed [ACC_W-1:0] x);
      logic signed [DATA_WIDTH-1:0] r;
      if (x > SAT_MAX) begin
         r = SAT_MAX[DATA_WIDTH-1:0];
      end else if (x < SAT_MIN) begin
         r = SAT_MIN[DATA_WIDTH-1:0];
      end else begin
         r = x[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/jss_mult.sv
// ----------------------------------------------------------------------------
// Joint setpoint smoother shared multiplier
// Signed multiplier with a registered product, reused for the unit
// conversion and the three weighted products of the smoothing sequence.
// ----------------------------------------------------------------------------
module jss_mult (
   input  logic                              clock,
   input  logic signed [jss_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [jss_pkg::MUL_W-1:0]  mul_b,
   output logic signed [jss_pkg::PROD_W-1:0] prod
);

   logic signed [jss_pkg::PROD_W-1:0] prod_ff;
   logic signed [jss_pkg::PROD_W-1:0] prod_in;

   // Form the full product
   assign prod_in = mul_a * mul_b;

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> src/joint_setpoint_smoother_core.sv
// ----------------------------------------------------------------------------
// Joint setpoint smoother core
// Converts a joint setpoint to fixed-point radians, smooths it against the two
// previous targets and tracks the direction of motion with a dead band.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   opcode, unit_code, position_value
//   rsp      out        rsp_valid / rsp_ready   target_position, direction_changed,
//                                               unit_error
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// A set transaction runs through the unit conversion, the three weighted
// products, the sum, the slope check and the output step; an init transaction
// goes from the unit conversion straight to the output step. One shared multiplier
// is used once for the unit conversion and three times for the weighted sum, so
// a new request is taken only once the previous one has left the sequencer.
// req_ready is high only while the sequencer is idle; the next transaction can
// be taken while the previous result still waits in the output register.
// A stalled result holds the sequencer at its last step until the slot frees.
// Synchronous reset clears the history and all handshake state and returns the limits to their reset values.
// ----------------------------------------------------------------------------
module joint_setpoint_smoother_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic [1:0]                             req_unit_code,
   input  logic signed [jss_pkg::DATA_WIDTH-1:0]  req_position_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [jss_pkg::DATA_WIDTH-1:0]  rsp_target_position,
   output logic                                   rsp_direction_changed,
   output logic                                   rsp_unit_error,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [jss_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [jss_pkg::DATA_WIDTH-1:0]         csr_data
);

   localparam int DW = jss_pkg::DATA_WIDTH;

   jss_pkg::state_type state_ff, state_in;

   logic                              opcode_ff, opcode_in;
   logic [1:0]                        unit_ff, unit_in;
   logic signed [DW-1:0]              value_ff, value_in;
   logic signed [jss_pkg::DIFF_W-1:0] span_ff, span_in;
   logic signed [jss_pkg::DIFF_W-1:0] opnd_ff, opnd_in;
   logic signed [DW-1:0]              u_ff, u_in;
   logic                              err_ff, err_in;
   logic signed [jss_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DW-1:0]              result_ff, result_in;
   logic                              new_neg_ff, new_neg_in;

   logic signed [DW-1:0]              newest_ff, newest_in;
   logic signed [DW-1:0]              older_ff, older_in;
   logic                              slope_neg_ff, slope_neg_in;

   logic signed [DW-1:0]              max_ff, max_in;
   logic signed [DW-1:0]              min_ff, min_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]              rsp_target_ff, rsp_target_in;
   logic                              rsp_changed_ff, rsp_changed_in;
   logic                              rsp_error_ff, rsp_error_in;

   logic signed [jss_pkg::MUL_W-1:0]  mul_a;
   logic signed [jss_pkg::MUL_W-1:0]  mul_b;
   logic signed [jss_pkg::PROD_W-1:0] prod;

   logic signed [jss_pkg::ACC_W-1:0]  prod_ext;
   logic signed [jss_pkg::ACC_W-1:0]  deg_acc;
   logic signed [jss_pkg::ACC_W-1:0]  scl_acc;
   logic signed [jss_pkg::ACC_W-1:0]  sum_acc;
   logic signed [jss_pkg::ACC_W-1:0]  sum_shr;
   logic signed [jss_pkg::DIFF_W-1:0] slope;
   logic                              out_free;

   // Shared multiplier
   jss_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Product views at accumulator width
   assign prod_ext = jss_pkg::ACC_W'(prod);
   assign deg_acc  = prod_ext >>> jss_pkg::WSHIFT;
   assign scl_acc  = (prod_ext >>> (jss_pkg::FRAC_BITS + 1)) + jss_pkg::ACC_W'(min_ff);
   assign sum_acc  = acc_ff + prod_ext;
   assign sum_shr  = sum_acc >>> jss_pkg::WSHIFT;
   assign slope    = jss_pkg::DIFF_W'(result_ff) - jss_pkg::DIFF_W'(newest_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Pick the multiplier operands for the current step
   always_comb begin
      mul_a = jss_pkg::MUL_W'(u_ff);
      mul_b = jss_pkg::W_NEW;
      case (state_ff)
         jss_pkg::ST_CONV: begin
            if (unit_ff == jss_pkg::UNIT_DEG) begin
               mul_a = jss_pkg::MUL_W'(value_ff);
               mul_b = jss_pkg::DEG2RAD;
            end else begin
               mul_a = jss_pkg::MUL_W'(span_ff);
               mul_b = jss_pkg::MUL_W'(opnd_ff);
            end
         end
         jss_pkg::ST_MUL_MID: begin
            mul_a = jss_pkg::MUL_W'(newest_ff);
            mul_b = jss_pkg::W_MID;
         end
         jss_pkg::ST_MUL_OLD: begin
            mul_a = jss_pkg::MUL_W'(older_ff);
            mul_b = jss_pkg::W_OLD;
         end
         default: begin
            mul_a = jss_pkg::MUL_W'(u_ff);
            mul_b = jss_pkg::W_NEW;
         end
      endcase
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      opcode_in      = opcode_ff;
      unit_in        = unit_ff;
      value_in       = value_ff;
      span_in        = span_ff;
      opnd_in        = opnd_ff;
      u_in           = u_ff;
      err_in         = err_ff;
      acc_in         = acc_ff;
      result_in      = result_ff;
      new_neg_in     = new_neg_ff;
      newest_in      = newest_ff;
      older_in       = older_ff;
      slope_neg_in   = slope_neg_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_target_in  = rsp_target_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_error_in   = rsp_error_ff;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            jss_pkg::CSR_MAX_ANGLE: max_in = $signed(csr_data);
            jss_pkg::CSR_MIN_ANGLE: min_in = $signed(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         // Capture the transaction and prepare the scale operands
         jss_pkg::ST_IDLE: begin
            if (req_valid) begin
               opcode_in = req_opcode;
               unit_in   = req_unit_code;
               value_in  = req_position_value;
               span_in   = jss_pkg::DIFF_W'(max_ff) - jss_pkg::DIFF_W'(min_ff);
               opnd_in   = jss_pkg::DIFF_W'(req_position_value) + jss_pkg::ONE_FX;
               state_in  = jss_pkg::ST_CONV;
            end
         end
         // Conversion product is in flight
         jss_pkg::ST_CONV: begin
            state_in = jss_pkg::ST_UNIT;
         end
         // Finish the unit conversion
         jss_pkg::ST_UNIT: begin
            err_in = 1'b0;
            case (unit_ff)
               jss_pkg::UNIT_RAD:   u_in = value_ff;
               jss_pkg::UNIT_DEG:   u_in = jss_pkg::sat_acc(deg_acc);
               jss_pkg::UNIT_SCALE: u_in = jss_pkg::sat_acc(scl_acc);
               default: begin
                  u_in   = '0;
                  err_in = 1'b1;
               end
            endcase
            result_in = u_in;
            if (opcode_ff == jss_pkg::OP_INIT) begin
               state_in = jss_pkg::ST_OUT;
            end else begin
               state_in = jss_pkg::ST_MUL_NEW;
            end
         end
         jss_pkg::ST_MUL_NEW: begin
            state_in = jss_pkg::ST_MUL_MID;
         end
         // Start the weighted sum
         jss_pkg::ST_MUL_MID: begin
            acc_in   = prod_ext;
            state_in = jss_pkg::ST_MUL_OLD;
         end
         jss_pkg::ST_MUL_OLD: begin
            acc_in   = sum_acc;
            state_in = jss_pkg::ST_SUM;
         end
         // Floor to the grid and clamp
         jss_pkg::ST_SUM: begin
            result_in = jss_pkg::sat_acc(sum_shr);
            state_in  = jss_pkg::ST_SLOPE;
         end
         // Update the slope sign outside the dead band
         jss_pkg::ST_SLOPE: begin
            if (slope > jss_pkg::DB_HI || slope < jss_pkg::DB_LO) begin
               new_neg_in = slope[jss_pkg::DIFF_W-1];
            end else begin
               new_neg_in = slope_neg_ff;
            end
            state_in = jss_pkg::ST_OUT;
         end
         // Commit history and hand the result over
         jss_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = result_ff;
               rsp_error_in  = err_ff;
               if (opcode_ff == jss_pkg::OP_INIT) begin
                  newest_in      = result_ff;
                  older_in       = result_ff;
                  slope_neg_in   = 1'b0;
                  rsp_changed_in = 1'b0;
               end else begin
                  older_in       = newest_ff;
                  newest_in      = result_ff;
                  slope_neg_in   = new_neg_ff;
                  rsp_changed_in = new_neg_ff != slope_neg_ff;
               end
               state_in = jss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jss_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         newest_ff    <= '0;
         older_ff     <= '0;
         slope_neg_ff <= 1'b0;
         max_ff       <= jss_pkg::MAX_ANGLE_RST;
         min_ff       <= jss_pkg::MIN_ANGLE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         newest_ff    <= newest_in;
         older_ff     <= older_in;
         slope_neg_ff <= slope_neg_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      opcode_ff      <= opcode_in;
      unit_ff        <= unit_in;
      value_ff       <= value_in;
      span_ff        <= span_in;
      opnd_ff        <= opnd_in;
      u_ff           <= u_in;
      err_ff         <= err_in;
      acc_ff         <= acc_in;
      result_ff      <= result_in;
      new_neg_ff     <= new_neg_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign req_ready             = state_ff == jss_pkg::ST_IDLE;
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_target_position   = rsp_target_ff;
   assign rsp_direction_changed = rsp_changed_ff;
   assign rsp_unit_error        = rsp_error_ff;

endmodule

>>> src/jss_checker.sv
// ----------------------------------------------------------------------------
// Joint setpoint smoother port checker
// Watches the core's ports for sequencing and reset behavior.
// ----------------------------------------------------------------------------
`include "joint_setpoint_smoother_core_macros.svh"

module jss_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [jss_pkg::DATA_WIDTH-1:0] rsp_target_position,
   input logic                                  rsp_direction_changed,
   input logic                                  rsp_unit_error
);

   // Hold a stalled result
   `JSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_target_position) && $stable(rsp_direction_changed) && $stable(rsp_unit_error), "stalled result changed")

   // Drop ready for the duration of a transaction
   `JSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // No result in the cycle right after an accept with an empty output
   `JSS_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready && (!rsp_valid || rsp_ready), !rsp_valid, "result appeared too early")

   // Reset empties the output
   `JSS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind joint_setpoint_smoother_core jss_checker u_jss_checker (.*);

>>> bench/joint_setpoint_smoother_core_test.sv
// ----------------------------------------------------------------------------
// Joint setpoint smoother core testbench
// Drives setpoints in every unit through the request channel, writes the joint
// limits between phases and compares each smoothed target, direction flag and
// unit error flag with a cycle-free predictor kept in step with the block.
// ----------------------------------------------------------------------------
module joint_setpoint_smoother_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = jss_pkg::DATA_WIDTH;
   localparam int FB = jss_pkg::FRAC_BITS;
   localparam logic [1:0] UNIT_INVALID = 2'd3;
   // Settling allowance used at the end of the run
   localparam int RSP_LATENCY = 12;
   localparam int SHIFT_Q32 = 32;
   localparam int DEAD_BAND = (1 << FB) / 1000;
   localparam int ONE_RAW = 1 << FB;

   typedef logic signed [DW-1:0] fx_type;
   typedef logic signed [127:0] wide_type;

   // Smoothing weights and degree factor as Q.32 fractions
   localparam wide_type GAIN_NEW = 128'sd3006477107;
   localparam wide_type GAIN_MID = 128'sd858993459;
   localparam wide_type GAIN_OLD = 128'sd429496730;
   localparam wide_type DEG_GAIN = 128'sd74961321;
   localparam wide_type ONE_WIDE = 128'sd1 <<< FB;
   localparam wide_type FX_HI = (128'sd1 <<< (DW - 1)) - 128'sd1;
   localparam wide_type FX_LO = -(128'sd1 <<< (DW - 1));

   typedef struct {
      fx_type target;
      logic   turned;
      logic   bad_unit;
   } target_type;

   // Ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic [1:0] req_unit_code = 2'd0;
   fx_type req_position_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   fx_type rsp_target_position;
   logic rsp_direction_changed;
   logic rsp_unit_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [jss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [DW-1:0] csr_data = '0;

   // Predicted block state, at reset values
   fx_type limit_max = 32'sd205887;
   fx_type limit_min = -32'sd205887;
   fx_type hist_newest = '0;
   fx_type hist_older = '0;
   logic slope_down = 1'b0;

   target_type expected_targets[$];

   // Traffic control
   bit source_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;
   int sink_hold = 0;
   int path_pos = 0;
   int path_step = 0;
   int path_left = 0;

   // Run statistics
   int items_sent = 0;
   int init_count = 0;
   int bad_unit_count = 0;
   int limit_writes = 0;
   int targets_checked = 0;
   int turns_seen = 0;
   int error_count = 0;

   joint_setpoint_smoother_core uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_unit_code         (req_unit_code),
      .req_position_value    (req_position_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_target_position   (rsp_target_position),
      .rsp_direction_changed (rsp_direction_changed),
      .rsp_unit_error        (rsp_unit_error),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Clamp an exact intermediate to the data width
   function automatic fx_type clamp_fx(input wide_type x);
      if (x > FX_HI) return fx_type'(FX_HI);
      if (x < FX_LO) return fx_type'(FX_LO);
      return fx_type'(x);
   endfunction

   // Convert a setpoint in the given unit to fixed-point radians
   function automatic fx_type to_radians(input logic [1:0] unit, input fx_type value);
      wide_type v;
      wide_type span;
      v = value;
      span = limit_max;
      span = span - limit_min;
      case (unit)
         jss_pkg::UNIT_RAD:   return value;
         jss_pkg::UNIT_DEG:   return clamp_fx((v * DEG_GAIN) >>> SHIFT_Q32);
         jss_pkg::UNIT_SCALE: return clamp_fx(((span * (v + ONE_WIDE)) >>> (FB + 1)) + limit_min);
         default:             return '0;
      endcase
   endfunction

   // Advance the predicted history by one command and return its target
   function automatic target_type smooth_setpoint(input logic op, input logic [1:0] unit,
                                                  input fx_type value);
      target_type r;
      fx_type u;
      wide_type acc;
      wide_type slope;
      logic was_down;
      u = to_radians(unit, value);
      r.bad_unit = (unit == UNIT_INVALID);
      r.turned = 1'b0;
      if (op == jss_pkg::OP_INIT) begin
         hist_newest = u;
         hist_older = u;
         slope_down = 1'b0;
      end else begin
         acc = wide_type'(u) * GAIN_NEW + wide_type'(hist_newest) * GAIN_MID
             + wide_type'(hist_older) * GAIN_OLD;
         was_down = slope_down;
         hist_older = hist_newest;
         hist_newest = clamp_fx(acc >>> SHIFT_Q32);
         slope = wide_type'(hist_newest) - wide_type'(hist_older);
         // Only a slope outside the dead band updates the direction
         if (slope > DEAD_BAND || slope < -DEAD_BAND) begin
            slope_down = (slope < 0);
         end
         r.turned = (slope_down != was_down);
      end
      r.target = hist_newest;
      return r;
   endfunction

   // Offer one setpoint, hold it until accepted, then record the prediction
   task automatic send_setpoint(input logic op, input logic [1:0] unit, input fx_type value);
      if (source_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_unit_code <= unit;
      req_position_value <= value;
      do @(posedge clock); while (!req_ready);
      expected_targets.push_back(smooth_setpoint(op, unit, value));
      items_sent++;
      if (op == jss_pkg::OP_INIT) init_count++;
      if (unit == UNIT_INVALID) bad_unit_count++;
   endtask

   // Drop the request and hold until every predicted target has come back
   task automatic wait_for_targets();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_targets.size() != 0);
   endtask

   // Write both joint limits, upper first; only called with the block idle
   task automatic write_joint_limits(input fx_type upper, input fx_type lower);
      csr_valid <= 1'b1;
      csr_index <= jss_pkg::CSR_MAX_ANGLE;
      csr_data <= upper;
      do @(posedge clock); while (!csr_ready);
      limit_max = upper;
      csr_index <= jss_pkg::CSR_MIN_ANGLE;
      csr_data <= lower;
      do @(posedge clock); while (!csr_ready);
      limit_min = lower;
      csr_valid <= 1'b0;
      limit_writes += 2;
   endtask

   // Random setpoint: mostly a smooth trajectory, some full-range noise
   task automatic send_random_setpoint();
      logic op;
      logic [1:0] unit;
      fx_type value;
      bit noise;
      op = ($urandom_range(0, 11) == 0) ? jss_pkg::OP_INIT : jss_pkg::OP_SET;
      noise = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 15))
         0:       unit = UNIT_INVALID;
         1, 2, 3: unit = jss_pkg::UNIT_DEG;
         4, 5, 6: unit = jss_pkg::UNIT_SCALE;
         default: unit = jss_pkg::UNIT_RAD;
      endcase
      // Ramp the trajectory, sometimes slower than the dead band
      if (path_left == 0) begin
         path_step = int'($urandom_range(0, 600)) - 300;
         path_left = $urandom_range(2, 12);
      end
      path_left--;
      path_pos += path_step;
      if (noise || unit == UNIT_INVALID) begin
         value = $urandom;
      end else if (unit == jss_pkg::UNIT_DEG) begin
         value = path_pos * 57;
      end else if (unit == jss_pkg::UNIT_SCALE) begin
         value = int'($urandom_range(0, 3 * ONE_RAW)) - 3 * ONE_RAW / 2;
      end else begin
         value = path_pos;
      end
      send_setpoint(op, unit, value);
   endtask

   // Extremes of every unit, invalid unit under both commands
   task automatic test_unit_conversion();
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD,   '0);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD,   32'sh7fffffff);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD,   32'sh80000000);
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_RAD,   32'sh7fffffff);
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_DEG,   32'sd11796480);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_DEG,   32'sh7fffffff);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_DEG,   32'sh80000000);
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_SCALE, -ONE_RAW);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, ONE_RAW);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, 32'sh7fffffff);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, 32'sh80000000);
      send_setpoint(jss_pkg::OP_SET,  UNIT_INVALID,        32'sh5a5a5a5a);
      send_setpoint(jss_pkg::OP_INIT, UNIT_INVALID,        -32'sd1);
   endtask

   // Direction turns, steps inside the dead band, init clearing a down slope
   task automatic test_direction_tracking();
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_RAD, 32'sd1000);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD, 32'sd1060);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD, 32'sd900);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD, 32'sd1000);
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_RAD, '0);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD, -ONE_RAW);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_RAD, 2 * ONE_RAW);
   endtask

   // Scale unit under widest, inverted and collapsed joint limits
   task automatic test_joint_limits();
      wait_for_targets();
      write_joint_limits(32'sh7fffffff, 32'sh80000000);
      send_setpoint(jss_pkg::OP_INIT, jss_pkg::UNIT_SCALE, ONE_RAW);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, -ONE_RAW);
      wait_for_targets();
      write_joint_limits(-32'sd102943, 32'sd102943);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, ONE_RAW / 2);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, 32'sh7fffffff);
      wait_for_targets();
      write_joint_limits(32'sd12345, 32'sd12345);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, 32'sh80000000);
      send_setpoint(jss_pkg::OP_SET,  jss_pkg::UNIT_SCALE, 32'sd77);
   endtask

   // Hold off the result side long enough that the input side stalls
   task automatic test_output_stall();
      int n;
      wait_for_targets();
      source_idle_on = 1'b0;
      sink_hold = 150;
      for (n = 0; n < 8; n++) send_random_setpoint();
      wait_for_targets();
      source_idle_on = 1'b1;
   endtask

   // Random trajectories in phases, each phase with its own joint limits
   task automatic test_random_motion(input int count);
      int n;
      fx_type lim;
      for (n = 0; n < count; n++) begin
         if (n % 200 == 0) begin
            wait_for_targets();
            lim = int'($urandom_range(0, 400000)) - 200000;
            case ($urandom_range(0, 4))
               0:       write_joint_limits(32'sd205887, -32'sd205887);
               1:       write_joint_limits(32'sh7fffffff, 32'sh80000000);
               2:       write_joint_limits(32'sh80000000, 32'sh7fffffff);
               3:       write_joint_limits(lim, lim - int'($urandom_range(0, 400000)));
               default: write_joint_limits($urandom, $urandom);
            endcase
         end
         send_random_setpoint();
      end
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_steady_stream(input int count);
      int n;
      wait_for_targets();
      write_joint_limits(32'sd205887, -32'sd205887);
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      for (n = 0; n < count; n++) send_random_setpoint();
   endtask

   // Result side: random stall bursts, plus a long hold when requested
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      target_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_targets.size() == 0) begin
            $display("%0t: unexpected result, target %0d", $time, rsp_target_position);
            error_count++;
         end else begin
            want = expected_targets.pop_front();
            targets_checked++;
            if (rsp_direction_changed) turns_seen++;
            if (rsp_target_position !== want.target) begin
               $display("%0t: target_position expected %0d got %0d",
                        $time, want.target, rsp_target_position);
               error_count++;
            end
            if (rsp_direction_changed !== want.turned) begin
               $display("%0t: direction_changed expected %0b got %0b",
                        $time, want.turned, rsp_direction_changed);
               error_count++;
            end
            if (rsp_unit_error !== want.bad_unit) begin
               $display("%0t: unit_error expected %0b got %0b",
                        $time, want.bad_unit, rsp_unit_error);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("status: fail");
      $finish;
   end

   // Test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_unit_conversion();
      test_direction_tracking();
      test_joint_limits();
      test_output_stall();
      test_random_motion(1400);
      test_steady_stream(200);
      wait_for_targets();
      repeat (RSP_LATENCY * 2) @(posedge clock);
      $display("covered %0d setpoints (%0d inits, %0d invalid units) over %0d limit writes",
               items_sent, init_count, bad_unit_count, limit_writes);
      $display("checked %0d targets, %0d direction changes, %0d mismatches",
               targets_checked, turns_seen, error_count);
      if (error_count == 0 && expected_targets.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
